>>> sv/kmlp_pkg.sv
package kmlp_pkg;

  localparam int KEY_NUM  = 5;
  localparam int PCT_KEYS = 3;
  localparam int KEY_MAXL = 9;
  localparam int VAL_W    = 16;
  localparam int PCT_W    = 7;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_N  = 8'h4E;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [7:0] PCT_MAX  = 8'd100;
  localparam logic [7:0] TEMP_MAX = 8'd199;

  // key text, left-justified and space padded to the longest key
  localparam logic [KEY_MAXL*8-1:0] KEY_TEXT [KEY_NUM] = '{
    "CPU=     ", "GPU=     ", "RAM=     ", "CPU_TEMP=", "GPU_TEMP="
  };
  localparam logic [3:0] KEY_LEN [KEY_NUM] = '{4'd4, 4'd4, 4'd4, 4'd9, 4'd9};

  typedef enum logic [1:0] {
    KS_SEARCH,
    KS_COLLECT,
    KS_DONE
  } key_status_e;

  typedef enum logic [1:0] {
    NP_WAIT,
    NP_DIGITS,
    NP_DONE
  } num_phase_e;

  typedef enum logic [2:0] {
    NA_NONE,
    NA_N,
    NA_NA,
    NA_NA_WS,
    NA_OTHER
  } na_state_e;

  typedef struct packed {
    logic              present;
    logic [VAL_W-1:0]  value;
  } lane_res_t;

  typedef struct packed {
    logic [PCT_W-1:0] cpu_load;
    logic [PCT_W-1:0] gpu_load;
    logic [PCT_W-1:0] ram_load;
    logic [VAL_W-1:0] cpu_therm;
    logic [VAL_W-1:0] gpu_therm;
  } metric_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [7:0] key_char(input logic [2:0] k, input logic [3:0] p);
    logic [KEY_MAXL*8-1:0] txt;
    logic [3:0]            r;
    txt = (k < 3'(KEY_NUM)) ? KEY_TEXT[k] : '0;
    r   = 4'(KEY_MAXL - 1) - p;
    return (p <= 4'(KEY_MAXL - 1)) ? txt[{r, 3'b000} +: 8] : 8'h00;
  endfunction

  function automatic logic [3:0] key_len(input logic [2:0] k);
    return (k < 3'(KEY_NUM)) ? KEY_LEN[k] : 4'd0;
  endfunction

endpackage

>>> sv/kmlp_byte_if.sv
interface kmlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> sv/kmlp_metric_if.sv
interface kmlp_metric_if;
  logic               valid;
  logic               ready;
  logic [6:0]         cpu_load;
  logic [6:0]         gpu_load;
  logic [6:0]         ram_load;
  logic signed [15:0] cpu_therm;
  logic signed [15:0] gpu_therm;

  modport source (output valid, output cpu_load, output gpu_load, output ram_load,
                  output cpu_therm, output gpu_therm, input ready);
  modport sink (input valid, input cpu_load, input gpu_load, input ram_load,
                input cpu_therm, input gpu_therm, output ready);
endinterface

>>> sv/keyed_metric_line_parser.sv
// Channel  | Dir | Payload                                         | Item
// in_if    | in  | rx_byte                                         | one received byte
// out_if   | out | cpu_load gpu_load ram_load cpu_therm gpu_therm  | held values after a line
// cfg      | in  | cfg_wdata_i (unknown temperature code)          | register write
//
// One byte per cycle while in_if is ready; each byte updates the per-key matchers
// in the cycle it is accepted, and a line result appears on out_if the cycle after its
// newline when the result register is free or drains in that cycle.
// A result register plus one skid entry let bytes keep flowing while a result waits;
// in_if stalls only while the skid entry is occupied.
// Reset clears line state, held values (to 0) and sets the unknown code to -1.
module keyed_metric_line_parser
  import kmlp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [VAL_W-1:0] cfg_wdata_i,
  kmlp_byte_if.sink        in_if,
  kmlp_metric_if.source    out_if
);

  logic [VAL_W-1:0] unknown_q;
  logic             has_text_q, has_text_d;
  logic [PCT_W-1:0] pct_q [PCT_KEYS];
  logic [VAL_W-1:0] cpu_therm_q, gpu_therm_q;
  logic             out_valid_q, skid_valid_q;
  metric_t          out_q, skid_q, res;

  logic             accept, is_nl, byte_en, line_end, res_valid, out_free;
  lane_res_t        lane_res [KEY_NUM];

  assign in_if.ready = !skid_valid_q;
  assign accept      = in_if.valid && in_if.ready;
  assign is_nl       = in_if.rx_byte == CH_NL;
  assign byte_en     = accept && !is_nl;
  assign line_end    = accept && is_nl;
  assign res_valid   = line_end && has_text_q;
  assign out_free    = !out_valid_q || out_if.ready;

  for (genvar k = 0; k < KEY_NUM; k++) begin : g_lane
    kmlp_key_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .key_idx_i     (3'(k)),
      .byte_en_i     (byte_en),
      .line_end_i    (line_end),
      .byte_i        (in_if.rx_byte),
      .unknown_code_i(unknown_q),
      .res_o         (lane_res[k])
    );
  end

  always_comb begin
    has_text_d = has_text_q;
    if (line_end) has_text_d = 1'b0;
    else if (byte_en && !is_ws(in_if.rx_byte)) has_text_d = 1'b1;
  end

  // held values after this line: absent keys keep theirs
  always_comb begin
    res.cpu_load  = lane_res[0].present ? lane_res[0].value[PCT_W-1:0] : pct_q[0];
    res.gpu_load  = lane_res[1].present ? lane_res[1].value[PCT_W-1:0] : pct_q[1];
    res.ram_load  = lane_res[2].present ? lane_res[2].value[PCT_W-1:0] : pct_q[2];
    res.cpu_therm = lane_res[3].present ? lane_res[3].value : cpu_therm_q;
    res.gpu_therm = lane_res[4].present ? lane_res[4].value : gpu_therm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unknown_q   <= '1;
      has_text_q  <= 1'b0;
      pct_q       <= '{default: '0};
      cpu_therm_q <= '0;
      gpu_therm_q <= '0;
    end else begin
      if (cfg_we_i) unknown_q <= cfg_wdata_i;
      has_text_q <= has_text_d;
      if (res_valid) begin
        pct_q[0]    <= res.cpu_load;
        pct_q[1]    <= res.gpu_load;
        pct_q[2]    <= res.ram_load;
        cpu_therm_q <= res.cpu_therm;
        gpu_therm_q <= res.gpu_therm;
      end
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.cpu_load  = out_q.cpu_load;
  assign out_if.gpu_load  = out_q.gpu_load;
  assign out_if.ram_load  = out_q.ram_load;
  assign out_if.cpu_therm = out_q.cpu_therm;
  assign out_if.gpu_therm = out_q.gpu_therm;

endmodule

>>> sv/kmlp_key_lane.sv
module kmlp_key_lane
  import kmlp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       key_idx_i,
  input  logic             byte_en_i,
  input  logic             line_end_i,
  input  logic [7:0]       byte_i,
  input  logic [VAL_W-1:0] unknown_code_i,
  output lane_res_t        res_o
);

  key_status_e status_q, status_d;
  num_phase_e  phase_q, phase_d;
  na_state_e   na_q, na_d;
  logic [3:0]  prog_q, prog_d;
  logic [7:0]  acc_q, acc_d;
  logic        neg_q, neg_d;

  logic        ws, digit, is_temp;
  logic [3:0]  dval;
  logic [11:0] acc_next;
  logic [3:0]  prog_inc;
  logic [7:0]  lim, mag;

  assign ws       = is_ws(byte_i);
  assign digit    = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign dval     = 4'(byte_i - CH_ZERO);
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {8'h00, dval};
  assign prog_inc = prog_q + 4'd1;
  assign is_temp  = key_idx_i >= 3'(PCT_KEYS);

  // next-state logic
  always_comb begin
    status_d = status_q;
    phase_d  = phase_q;
    na_d     = na_q;
    prog_d   = prog_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    if (line_end_i) begin
      status_d = KS_SEARCH;
      phase_d  = NP_WAIT;
      na_d     = NA_NONE;
      prog_d   = '0;
      acc_d    = '0;
      neg_d    = 1'b0;
    end else if (byte_en_i) begin
      case (status_q)
        KS_SEARCH: begin
          if ((prog_q < key_len(key_idx_i)) && (byte_i == key_char(key_idx_i, prog_q))) begin
            if (prog_inc == key_len(key_idx_i)) begin
              status_d = KS_COLLECT;
              prog_d   = '0;
            end else begin
              prog_d = prog_inc;
            end
          end else begin
            prog_d = (byte_i == key_char(key_idx_i, 4'd0)) ? 4'd1 : 4'd0;
          end
        end
        KS_COLLECT: begin
          if (byte_i == CH_SEMI) begin
            status_d = KS_DONE;
          end else begin
            case (phase_q)
              NP_WAIT: begin
                if ((byte_i == CH_PLUS) || (byte_i == CH_MINUS)) begin
                  neg_d   = byte_i == CH_MINUS;
                  phase_d = NP_DIGITS;
                end else if (digit) begin
                  acc_d   = {4'h0, dval};
                  phase_d = NP_DIGITS;
                end else if (!ws) begin
                  phase_d = NP_DONE;
                end
              end
              NP_DIGITS: begin
                if (digit) begin
                  acc_d = (acc_next > 12'd255) ? 8'd255 : acc_next[7:0];
                end else begin
                  phase_d = NP_DONE;
                end
              end
              default: ;
            endcase
            case (na_q)
              NA_NONE: begin
                if ((byte_i == CH_UP_N) || (byte_i == CH_LO_N)) na_d = NA_N;
                else if (!ws) na_d = NA_OTHER;
              end
              NA_N:     na_d = ((byte_i == CH_UP_A) || (byte_i == CH_LO_A)) ? NA_NA : NA_OTHER;
              NA_NA:    na_d = ws ? NA_NA_WS : NA_OTHER;
              NA_NA_WS: if (!ws) na_d = NA_OTHER;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // value for the line that ends now
  always_comb begin
    lim = is_temp ? TEMP_MAX : PCT_MAX;
    mag = neg_q ? 8'd0 : acc_q;
    res_o.present = status_q != KS_SEARCH;
    if (is_temp && (na_q != NA_N) && (na_q != NA_OTHER)) begin
      res_o.value = unknown_code_i;
    end else begin
      res_o.value = {8'h00, (mag > lim) ? lim : mag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= KS_SEARCH;
      phase_q  <= NP_WAIT;
      na_q     <= NA_NONE;
      prog_q   <= '0;
      acc_q    <= '0;
      neg_q    <= 1'b0;
    end else begin
      status_q <= status_d;
      phase_q  <= phase_d;
      na_q     <= na_d;
      prog_q   <= prog_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
    end
  end

endmodule
